// ----- rtl/core/lob_pkg.sv -----
// Package: shared types, constants and helpers of the limit order book core.
`timescale 1ns / 1ps
package lob_pkg;

  // Table geometry
  localparam int ORDER_SLOTS = 256;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int MAX_DEPTH   = 16;
  localparam int NL_W        = $clog2(MAX_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int PRICE_W = 32;
  localparam int ID_W    = 32;
  localparam int QTY_W   = 31;
  localparam int SEQ_W   = 32;
  localparam int TOT_W   = 39;
  localparam int CNT_W   = 9;
  localparam int REQ_W   = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_REDUCE = 2'd2,
    CMD_DEPTH  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_NOT_LIMIT = 3'd2,
    STAT_CROSS     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_INCREASE  = 3'd5,
    STAT_FULL      = 3'd6
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_WAIT,
    S_FIND_WAIT,
    S_REFR_WAIT,
    S_DEPTH_WAIT,
    S_DEPTH_MID,
    S_DEPTH_LAST,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [ID_W-1:0]    order_id;
    logic               side;
    logic               is_limit;
    logic [PRICE_W-1:0] price;
    logic signed [31:0] quantity;
    logic [REQ_W-1:0]   depth_levels;
  } in_t;

  typedef struct packed {
    stat_e              status;
    logic               level_valid;
    logic [PRICE_W-1:0] level_price;
    logic [TOT_W-1:0]   level_total;
    logic [CNT_W-1:0]   level_orders;
    logic               last;
    logic [PRICE_W-1:0] bid_price;
    logic               bid_present;
    logic [PRICE_W-1:0] ask_price;
    logic               ask_present;
    logic [CNT_W-1:0]   bid_level_count;
    logic [CNT_W-1:0]   ask_level_count;
  } out_t;

  // One stored order
  typedef struct packed {
    logic               side;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [SEQ_W-1:0]   seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  accept;
    logic  scan_start;
    logic  add_commit;
    logic  cancel_commit;
    logic  reduce_commit;
    logic  refresh_commit;
    logic  pend_take;
    logic  out_load;
    logic  out_level;
    logic  out_last;
    stat_e out_status;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e  command;
    stat_e add_pre;
    logic  qpos;
    logic  depth_zero;
    logic  scan_done;
    logic  free_found;
    logic  cand_found;
    logic  inc_refused;
    logic  lvl_found;
    logic  have_pend;
    logic  lvl_last;
    logic  out_free;
  } stat_t;

  // a strictly better than b on side s (bid: higher, ask: lower)
  function automatic logic price_better(logic s, logic [PRICE_W-1:0] a,
                                        logic [PRICE_W-1:0] b);
    price_better = s ? (a < b) : (a > b);
  endfunction

endpackage

// ----- rtl/core/lob_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lob_ctrl.sv -----
// Controller: command sequencer of the order book.
`timescale 1ns / 1ps
module lob_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lob_pkg::stat_t st_i,
  output lob_pkg::ctrl_t ctl_o
);
  import lob_pkg::*;

  state_e state_q, state_d;
  stat_e  resp_q, resp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= STAT_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (st_i.command)
          CMD_ADD: begin
            if (st_i.add_pre != STAT_OK) begin
              resp_d  = st_i.add_pre;
              state_d = S_RESP;
            end else begin
              state_d = S_ADD_WAIT;
            end
          end
          CMD_CANCEL: state_d = S_FIND_WAIT;
          CMD_REDUCE: begin
            if (!st_i.qpos) begin
              resp_d  = STAT_INVALID;
              state_d = S_RESP;
            end else begin
              state_d = S_FIND_WAIT;
            end
          end
          CMD_DEPTH: begin
            if (st_i.depth_zero) begin
              resp_d  = STAT_OK;
              state_d = S_RESP;
            end else begin
              state_d = S_DEPTH_WAIT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD_WAIT: begin
        if (st_i.scan_done) begin
          resp_d  = st_i.free_found ? STAT_OK : STAT_FULL;
          state_d = S_RESP;
        end
      end
      S_FIND_WAIT: begin
        if (st_i.scan_done) begin
          priority if (!st_i.cand_found) begin
            resp_d  = STAT_NOT_FOUND;
            state_d = S_RESP;
          end else if (st_i.command == CMD_CANCEL) begin
            state_d = S_REFR_WAIT;
          end else if (st_i.inc_refused) begin
            resp_d  = STAT_INCREASE;
            state_d = S_RESP;
          end else begin
            resp_d  = STAT_OK;
            state_d = S_RESP;
          end
        end
      end
      S_REFR_WAIT: begin
        if (st_i.scan_done) begin
          resp_d  = STAT_OK;
          state_d = S_RESP;
        end
      end
      S_DEPTH_WAIT: begin
        if (st_i.scan_done) begin
          priority if (st_i.lvl_found && st_i.have_pend) begin
            state_d = S_DEPTH_MID;
          end else if (st_i.lvl_found) begin
            state_d = st_i.lvl_last ? S_DEPTH_LAST : S_DEPTH_WAIT;
          end else if (st_i.have_pend) begin
            state_d = S_DEPTH_LAST;
          end else begin
            resp_d  = STAT_OK;
            state_d = S_RESP;
          end
        end
      end
      S_DEPTH_MID: begin
        if (st_i.out_free) state_d = st_i.lvl_last ? S_DEPTH_LAST : S_DEPTH_WAIT;
      end
      S_DEPTH_LAST, S_RESP: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o            = '0;
    ctl_o.out_status = STAT_OK;
    in_stall_o       = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: ctl_o.accept = in_valid_i;
      S_DECODE: begin
        unique case (st_i.command)
          CMD_ADD:    ctl_o.scan_start = (st_i.add_pre == STAT_OK);
          CMD_CANCEL: ctl_o.scan_start = 1'b1;
          CMD_REDUCE: ctl_o.scan_start = st_i.qpos;
          CMD_DEPTH:  ctl_o.scan_start = !st_i.depth_zero;
          default:    ctl_o.scan_start = 1'b0;
        endcase
      end
      S_ADD_WAIT: ctl_o.add_commit = st_i.scan_done && st_i.free_found;
      S_FIND_WAIT: begin
        if (st_i.scan_done && st_i.cand_found) begin
          if (st_i.command == CMD_CANCEL) begin
            ctl_o.cancel_commit = 1'b1;
            ctl_o.scan_start    = 1'b1;
          end else begin
            ctl_o.reduce_commit = !st_i.inc_refused;
          end
        end
      end
      S_REFR_WAIT: ctl_o.refresh_commit = st_i.scan_done;
      S_DEPTH_WAIT: begin
        if (st_i.scan_done && st_i.lvl_found && !st_i.have_pend) begin
          ctl_o.pend_take  = 1'b1;
          ctl_o.scan_start = !st_i.lvl_last;
        end
      end
      S_DEPTH_MID: begin
        if (st_i.out_free) begin
          ctl_o.out_load   = 1'b1;
          ctl_o.out_level  = 1'b1;
          ctl_o.pend_take  = 1'b1;
          ctl_o.scan_start = !st_i.lvl_last;
        end
      end
      S_DEPTH_LAST: begin
        ctl_o.out_load  = st_i.out_free;
        ctl_o.out_level = 1'b1;
        ctl_o.out_last  = 1'b1;
      end
      S_RESP: begin
        ctl_o.out_load   = st_i.out_free;
        ctl_o.out_last   = 1'b1;
        ctl_o.out_status = resp_q;
      end
      default: ctl_o.accept = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/lob_dp.sv -----
// Datapath: order table, scan accumulators, book summary and result register.
`timescale 1ns / 1ps
module lob_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lob_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lob_pkg::out_t  out_data_o,
  input  lob_pkg::ctrl_t ctl_i,
  output lob_pkg::stat_t st_o
);
  import lob_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ORDER_SLOTS - 1);

  // Held item and book state
  in_t                    item_q, item_d;
  logic [NL_W-1:0]        n_q, n_d, k_q, k_d;
  logic                   ref_side_q, ref_side_d;
  logic [PRICE_W-1:0]     ref_price_q, ref_price_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [SEQ_W-1:0]       arrival_q, arrival_d;
  logic [PRICE_W-1:0]     bb_q, bb_d, ba_q, ba_d;
  logic                   bp_q, bp_d, ap_q, ap_d;
  logic [CNT_W-1:0]       blc_q, blc_d, alc_q, alc_d;

  // Scan sequencing
  logic              scan_act_q, scan_act_d, rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0] scan_idx_q, scan_idx_d, rd_idx_q, rd_idx_d;

  // Scan accumulators
  logic              free_f_q, free_f_d, same_f_q, same_f_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic              sb_f_q, sb_f_d, sa_f_q, sa_f_d;
  logic [PRICE_W-1:0] sb_p_q, sb_p_d, sa_p_q, sa_p_d;
  logic              cb_f_q, cb_f_d, ca_f_q, ca_f_d;
  logic [SLOT_W-1:0] cb_idx_q, cb_idx_d, ca_idx_q, ca_idx_d;
  logic [PRICE_W-1:0] cb_p_q, cb_p_d, ca_p_q, ca_p_d;
  logic [SEQ_W-1:0]  cb_s_q, cb_s_d, ca_s_q, ca_s_d;
  logic [QTY_W-1:0]  cb_qty_q, cb_qty_d, ca_qty_q, ca_qty_d;
  logic              lf_q, lf_d;
  logic [PRICE_W-1:0] lp_q, lp_d;
  logic [TOT_W-1:0]  lt_q, lt_d;
  logic [CNT_W-1:0]  lc_q, lc_d;

  // Pending depth level, also the bound of the next level scan
  logic              hp_q, hp_d;
  logic [PRICE_W-1:0] pp_q, pp_d;
  logic [TOT_W-1:0]  pt_q, pt_d;
  logic [CNT_W-1:0]  pc_q, pc_d;

  // Result register
  logic ov_q, ov_d;
  out_t od_q, od_d;

  // RAM port signals
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             e;
  logic               ev;

  // Selected match and misc decode
  logic               sel_bid;
  logic [SLOT_W-1:0]  sel_idx;
  logic [PRICE_W-1:0] sel_price;
  logic [SEQ_W-1:0]   sel_seq;
  logic [QTY_W-1:0]   sel_qty;
  logic               qpos;
  stat_e              add_pre;
  logic               out_free;

  lob_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ORDER_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  assign e  = entry_t'(ram_rdata);
  assign ev = rd_vld_q && valid_q[rd_idx_q];

  // First match: bids first, then asks
  assign sel_bid   = cb_f_q;
  assign sel_idx   = sel_bid ? cb_idx_q : ca_idx_q;
  assign sel_price = sel_bid ? cb_p_q   : ca_p_q;
  assign sel_seq   = sel_bid ? cb_s_q   : ca_s_q;
  assign sel_qty   = sel_bid ? cb_qty_q : ca_qty_q;

  assign qpos     = !item_q.quantity[31] && (item_q.quantity != '0);
  assign out_free = !ov_q || !out_stall_i;

  // Add checks that need no scan
  always_comb begin
    priority if (!qpos || item_q.price == '0) begin
      add_pre = STAT_INVALID;
    end else if (!item_q.is_limit) begin
      add_pre = STAT_NOT_LIMIT;
    end else if (!item_q.side ? (ap_q && item_q.price >= ba_q)
                              : (bp_q && item_q.price <= bb_q)) begin
      add_pre = STAT_CROSS;
    end else begin
      add_pre = STAT_OK;
    end
  end

  // Table writes: new order or reduced quantity
  always_comb begin
    ram_we    = ctl_i.add_commit || ctl_i.reduce_commit;
    ram_waddr = ctl_i.add_commit ? free_idx_q : sel_idx;
    if (ctl_i.add_commit) begin
      ram_wdata = '{side: item_q.side, id: item_q.order_id, price: item_q.price,
                    qty: item_q.quantity[QTY_W-1:0], seq: arrival_q};
    end else begin
      ram_wdata = '{side: !sel_bid, id: item_q.order_id, price: sel_price,
                    qty: item_q.quantity[QTY_W-1:0], seq: sel_seq};
    end
  end

  // Next-state logic of the datapath
  always_comb begin
    item_d = item_q; n_d = n_q; k_d = k_q;
    ref_side_d = ref_side_q; ref_price_d = ref_price_q;
    valid_d = valid_q; arrival_d = arrival_q;
    bb_d = bb_q; bp_d = bp_q; ba_d = ba_q; ap_d = ap_q;
    blc_d = blc_q; alc_d = alc_q;
    scan_act_d = scan_act_q; scan_idx_d = scan_idx_q;
    rd_vld_d = scan_act_q; rd_idx_d = scan_idx_q;
    free_f_d = free_f_q; free_idx_d = free_idx_q; same_f_d = same_f_q;
    sb_f_d = sb_f_q; sb_p_d = sb_p_q; sa_f_d = sa_f_q; sa_p_d = sa_p_q;
    cb_f_d = cb_f_q; cb_idx_d = cb_idx_q; cb_p_d = cb_p_q; cb_s_d = cb_s_q;
    cb_qty_d = cb_qty_q;
    ca_f_d = ca_f_q; ca_idx_d = ca_idx_q; ca_p_d = ca_p_q; ca_s_d = ca_s_q;
    ca_qty_d = ca_qty_q;
    lf_d = lf_q; lp_d = lp_q; lt_d = lt_q; lc_d = lc_q;
    hp_d = hp_q; pp_d = pp_q; pt_d = pt_q; pc_d = pc_q;
    ov_d = ov_q; od_d = od_q;

    // Item beat
    if (ctl_i.accept) begin
      item_d      = in_data_i;
      ref_side_d  = in_data_i.side;
      ref_price_d = in_data_i.price;
      hp_d        = 1'b0;
      k_d         = '0;
      if (32'(in_data_i.depth_levels) > MAX_DEPTH) n_d = NL_W'(MAX_DEPTH);
      else n_d = NL_W'(in_data_i.depth_levels);
    end

    // Address side of the scan
    if (scan_act_q) begin
      scan_idx_d = scan_idx_q + 1'b1;
      if (scan_idx_q == LAST_SLOT) scan_act_d = 1'b0;
    end

    // Data side of the scan
    if (rd_vld_q && !valid_q[rd_idx_q] && !free_f_q) begin
      free_f_d   = 1'b1;
      free_idx_d = rd_idx_q;
    end
    if (ev && e.side == ref_side_q && e.price == ref_price_q) same_f_d = 1'b1;
    if (ev && !e.side && (!sb_f_q || e.price > sb_p_q)) begin
      sb_f_d = 1'b1;
      sb_p_d = e.price;
    end
    if (ev && e.side && (!sa_f_q || e.price < sa_p_q)) begin
      sa_f_d = 1'b1;
      sa_p_d = e.price;
    end
    if (ev && !e.side && e.id == item_q.order_id &&
        (!cb_f_q || e.price > cb_p_q || (e.price == cb_p_q && e.seq < cb_s_q))) begin
      cb_f_d = 1'b1; cb_idx_d = rd_idx_q; cb_p_d = e.price;
      cb_s_d = e.seq; cb_qty_d = e.qty;
    end
    if (ev && e.side && e.id == item_q.order_id &&
        (!ca_f_q || e.price < ca_p_q || (e.price == ca_p_q && e.seq < ca_s_q))) begin
      ca_f_d = 1'b1; ca_idx_d = rd_idx_q; ca_p_d = e.price;
      ca_s_d = e.seq; ca_qty_d = e.qty;
    end
    // Next level beyond the pending one, with its total and order count
    if (ev && e.side == item_q.side &&
        (!hp_q || price_better(item_q.side, pp_q, e.price))) begin
      if (!lf_q || price_better(item_q.side, e.price, lp_q)) begin
        lf_d = 1'b1;
        lp_d = e.price;
        lt_d = TOT_W'(e.qty);
        lc_d = CNT_W'(1);
      end else if (e.price == lp_q) begin
        lt_d = lt_q + TOT_W'(e.qty);
        lc_d = lc_q + 1'b1;
      end
    end

    // Add: insert and update the summary
    if (ctl_i.add_commit) begin
      valid_d[free_idx_q] = 1'b1;
      arrival_d = arrival_q + 1'b1;
      if (!item_q.side) begin
        if (!same_f_q) blc_d = blc_q + 1'b1;
        if (!bp_q || item_q.price > bb_q) begin
          bb_d = item_q.price;
          bp_d = 1'b1;
        end
      end else begin
        if (!same_f_q) alc_d = alc_q + 1'b1;
        if (!ap_q || item_q.price < ba_q) begin
          ba_d = item_q.price;
          ap_d = 1'b1;
        end
      end
    end

    // Cancel: drop the order and remember its level for the refresh
    if (ctl_i.cancel_commit) begin
      valid_d[sel_idx] = 1'b0;
      ref_side_d       = !sel_bid;
      ref_price_d      = sel_price;
    end

    // Refresh after a cancel
    if (ctl_i.refresh_commit) begin
      bb_d = sb_f_q ? sb_p_q : '0;
      bp_d = sb_f_q;
      ba_d = sa_f_q ? sa_p_q : '0;
      ap_d = sa_f_q;
      if (!same_f_q) begin
        if (ref_side_q) alc_d = alc_q - 1'b1;
        else blc_d = blc_q - 1'b1;
      end
    end

    // Result register
    if (ctl_i.out_load) begin
      ov_d                 = 1'b1;
      od_d.status          = ctl_i.out_status;
      od_d.level_valid     = ctl_i.out_level;
      od_d.level_price     = ctl_i.out_level ? pp_q : '0;
      od_d.level_total     = ctl_i.out_level ? pt_q : '0;
      od_d.level_orders    = ctl_i.out_level ? pc_q : '0;
      od_d.last            = ctl_i.out_last;
      od_d.bid_price       = bb_q;
      od_d.bid_present     = bp_q;
      od_d.ask_price       = ba_q;
      od_d.ask_present     = ap_q;
      od_d.bid_level_count = blc_q;
      od_d.ask_level_count = alc_q;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    // Level found by the last scan becomes the pending one
    if (ctl_i.pend_take) begin
      hp_d = 1'b1;
      pp_d = lp_q;
      pt_d = lt_q;
      pc_d = lc_q;
      k_d  = k_q + 1'b1;
    end

    // Start a fresh pass
    if (ctl_i.scan_start) begin
      scan_act_d = 1'b1;
      scan_idx_d = '0;
      free_f_d = 1'b0; same_f_d = 1'b0;
      sb_f_d = 1'b0; sa_f_d = 1'b0;
      cb_f_d = 1'b0; ca_f_d = 1'b0;
      lf_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      arrival_q  <= '0;
      bb_q       <= '0;
      bp_q       <= 1'b0;
      ba_q       <= '0;
      ap_q       <= 1'b0;
      blc_q      <= '0;
      alc_q      <= '0;
      scan_act_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      free_f_q   <= 1'b0;
      same_f_q   <= 1'b0;
      sb_f_q     <= 1'b0;
      sa_f_q     <= 1'b0;
      cb_f_q     <= 1'b0;
      ca_f_q     <= 1'b0;
      lf_q       <= 1'b0;
      hp_q       <= 1'b0;
      k_q        <= '0;
      n_q        <= '0;
      ov_q       <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      arrival_q  <= arrival_d;
      bb_q       <= bb_d;
      bp_q       <= bp_d;
      ba_q       <= ba_d;
      ap_q       <= ap_d;
      blc_q      <= blc_d;
      alc_q      <= alc_d;
      scan_act_q <= scan_act_d;
      rd_vld_q   <= rd_vld_d;
      free_f_q   <= free_f_d;
      same_f_q   <= same_f_d;
      sb_f_q     <= sb_f_d;
      sa_f_q     <= sa_f_d;
      cb_f_q     <= cb_f_d;
      ca_f_q     <= ca_f_d;
      lf_q       <= lf_d;
      hp_q       <= hp_d;
      k_q        <= k_d;
      n_q        <= n_d;
      ov_q       <= ov_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    ref_side_q  <= ref_side_d;
    ref_price_q <= ref_price_d;
    scan_idx_q  <= scan_idx_d;
    rd_idx_q    <= rd_idx_d;
    free_idx_q  <= free_idx_d;
    sb_p_q      <= sb_p_d;
    sa_p_q      <= sa_p_d;
    cb_idx_q    <= cb_idx_d;
    cb_p_q      <= cb_p_d;
    cb_s_q      <= cb_s_d;
    cb_qty_q    <= cb_qty_d;
    ca_idx_q    <= ca_idx_d;
    ca_p_q      <= ca_p_d;
    ca_s_q      <= ca_s_d;
    ca_qty_q    <= ca_qty_d;
    lp_q        <= lp_d;
    lt_q        <= lt_d;
    lc_q        <= lc_d;
    pp_q        <= pp_d;
    pt_q        <= pt_d;
    pc_q        <= pc_d;
    od_q        <= od_d;
  end

  // Status to the controller
  always_comb begin
    st_o.command     = item_q.command;
    st_o.add_pre     = add_pre;
    st_o.qpos        = qpos;
    st_o.depth_zero  = (n_q == '0);
    st_o.scan_done   = !scan_act_q && !rd_vld_q;
    st_o.free_found  = free_f_q;
    st_o.cand_found  = cb_f_q || ca_f_q;
    st_o.inc_refused = item_q.quantity[QTY_W:0] > {1'b0, sel_qty};
    st_o.lvl_found   = lf_q;
    st_o.have_pend   = hp_q;
    st_o.lvl_last    = (k_q + 1'b1) == n_q;
    st_o.out_free    = out_free;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ----- rtl/core/limit_order_book_core.sv -----
// Top level: price-time priority limit order book core.
`timescale 1ns / 1ps
// The book holds up to ORDER_SLOTS resting orders in one table RAM with a
// single read port, and a command walks that table one slot per cycle.
// Add, reduce and a found-or-not cancel each take one pass, a successful
// cancel two (find, then refresh of best prices and level counts), and a
// depth query one pass per reported level, plus one more that finds the
// side exhausted when fewer levels rest than were asked for, so at most
// MAX_DEPTH passes. Early rejects of add and reduce skip the table pass.
// One command is in work at a time: the input is stalled from the accepted
// beat until its last result sits in the output register, which frees the
// input while that result waits to be taken. Table contents need no
// clearing after reset; per-slot valid flags start empty.
module limit_order_book_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lob_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lob_pkg::out_t out_data_o
);
  import lob_pkg::*;

  ctrl_t ctl;
  stat_t st;

  lob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  lob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .st_o        (st)
  );

endmodule

// ----- tb/lob_book_checker.sv -----
// Checker: watches both channels, predicts the order book and compares results.
`timescale 1ns / 1ps
module lob_book_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  lob_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  lob_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            results_seen_o
);
  import lob_pkg::*;

  // Predicted book contents
  logic              bk_valid [ORDER_SLOTS];
  logic              bk_side  [ORDER_SLOTS];
  logic [ID_W-1:0]   bk_id    [ORDER_SLOTS];
  logic [PRICE_W-1:0] bk_price [ORDER_SLOTS];
  logic [QTY_W-1:0]  bk_qty   [ORDER_SLOTS];
  logic [SEQ_W-1:0]  bk_seq   [ORDER_SLOTS];
  logic [SEQ_W-1:0]  arrivals;

  out_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic bit beats(logic s, logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    return s ? (a < b) : (a > b);
  endfunction

  function automatic bit top_price(logic s, output logic [PRICE_W-1:0] p);
    bit found;
    found = 0;
    p = '0;
    for (int i = 0; i < ORDER_SLOTS; i++)
      if (bk_valid[i] && bk_side[i] == s && (!found || beats(s, bk_price[i], p))) begin
        p = bk_price[i];
        found = 1;
      end
    return found;
  endfunction

  function automatic logic [CNT_W-1:0] levels_on(logic s);
    int n;
    bit seen;
    n = 0;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (bk_valid[i] && bk_side[i] == s) begin
        seen = 0;
        for (int j = 0; j < i; j++)
          if (bk_valid[j] && bk_side[j] == s && bk_price[j] == bk_price[i]) seen = 1;
        if (!seen) n++;
      end
    end
    return n[CNT_W-1:0];
  endfunction

  // First match of an id: bids best-first, then asks; earliest within a level
  function automatic int locate_id(logic [ID_W-1:0] id);
    int hit;
    for (int s = 0; s < 2; s++) begin
      hit = -1;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        if (bk_valid[i] && bk_side[i] == s[0] && bk_id[i] == id &&
            (hit < 0 || beats(s[0], bk_price[i], bk_price[hit]) ||
             (bk_price[i] == bk_price[hit] && bk_seq[i] < bk_seq[hit])))
          hit = i;
      end
      if (hit >= 0) return hit;
    end
    return -1;
  endfunction

  function automatic out_t book_result(stat_e st, logic lv, logic [PRICE_W-1:0] lp,
                                       logic [TOT_W-1:0] lt, logic [CNT_W-1:0] lo,
                                       logic lst);
    out_t r;
    logic [PRICE_W-1:0] p;
    r = '0;
    r.status = st;
    r.level_valid = lv;
    r.level_price = lp;
    r.level_total = lt;
    r.level_orders = lo;
    r.last = lst;
    r.bid_present = top_price(1'b0, p);
    r.bid_price = r.bid_present ? p : '0;
    r.ask_present = top_price(1'b1, p);
    r.ask_price = r.ask_present ? p : '0;
    r.bid_level_count = levels_on(1'b0);
    r.ask_level_count = levels_on(1'b1);
    return r;
  endfunction

  // Apply one command to the predicted book and queue its results
  task automatic apply_command(in_t c);
    stat_e st;
    logic [PRICE_W-1:0] opp, p, prev;
    bit has_opp, qpos, found, have_prev;
    int slot, idx, n, k;
    logic [TOT_W-1:0] tot;
    int cnt;
    out_t lvls[$];
    st = STAT_OK;
    qpos = (c.quantity > 0);
    case (c.command)
      CMD_ADD: begin
        has_opp = top_price(~c.side, opp);
        slot = -1;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) if (!bk_valid[i]) slot = i;
        if (!qpos || c.price == 0) st = STAT_INVALID;
        else if (!c.is_limit) st = STAT_NOT_LIMIT;
        else if (has_opp && (c.side ? c.price <= opp : c.price >= opp)) st = STAT_CROSS;
        else if (slot < 0) st = STAT_FULL;
        else begin
          bk_valid[slot] = 1;
          bk_side[slot] = c.side;
          bk_id[slot] = c.order_id;
          bk_price[slot] = c.price;
          bk_qty[slot] = c.quantity[QTY_W-1:0];
          bk_seq[slot] = arrivals;
          arrivals = arrivals + 1;
        end
      end
      CMD_CANCEL: begin
        idx = locate_id(c.order_id);
        if (idx < 0) st = STAT_NOT_FOUND;
        else bk_valid[idx] = 0;
      end
      CMD_REDUCE: begin
        if (!qpos) st = STAT_INVALID;
        else begin
          idx = locate_id(c.order_id);
          if (idx < 0) st = STAT_NOT_FOUND;
          else if (c.quantity[QTY_W-1:0] > bk_qty[idx]) st = STAT_INCREASE;
          else bk_qty[idx] = c.quantity[QTY_W-1:0];
        end
      end
      default: begin
        n = (c.depth_levels > MAX_DEPTH) ? MAX_DEPTH : c.depth_levels;
        have_prev = 0;
        prev = '0;
        for (k = 0; k < n; k++) begin
          found = 0;
          p = '0;
          for (int i = 0; i < ORDER_SLOTS; i++)
            if (bk_valid[i] && bk_side[i] == c.side &&
                !(have_prev && !beats(c.side, prev, bk_price[i])) &&
                (!found || beats(c.side, bk_price[i], p))) begin
              p = bk_price[i];
              found = 1;
            end
          if (!found) break;
          tot = '0;
          cnt = 0;
          for (int i = 0; i < ORDER_SLOTS; i++)
            if (bk_valid[i] && bk_side[i] == c.side && bk_price[i] == p) begin
              tot += bk_qty[i];
              cnt++;
            end
          lvls = {lvls, book_result(STAT_OK, 1'b1, p, tot, cnt[CNT_W-1:0], 1'b0)};
          prev = p;
          have_prev = 1;
        end
        if (lvls.size() > 0) begin
          lvls[lvls.size() - 1].last = 1'b1;
          expected_q = {expected_q, lvls};
          return;
        end
      end
    endcase
    expected_q = {expected_q, book_result(st, 1'b0, '0, '0, '0, 1'b1)};
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ORDER_SLOTS; i++) bk_valid[i] = 0;
      arrivals = '0;
      expected_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                     $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
    end
  end
endmodule

// ----- tb/tb_limit_order_book_core.sv -----
// Testbench top: drives commands into the order book core and gives the verdict.
`timescale 1ns / 1ps
module tb_limit_order_book_core;
  import lob_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int   fail_count, pending, results_seen;
  int   cycles = 0;
  int   send_idle = 0, recv_stall = 0;
  int   cmd_tally[4] = '{0, 0, 0, 0};
  logic [ID_W-1:0] live_ids[$];

  localparam int CYCLE_LIMIT = 10_000_000;

  always #6 clk_i = ~clk_i;

  limit_order_book_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  lob_book_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_limit_order_book_core: done, errors");
      $finish;
    end
  end

  // Receiver stall, percentage set per phase
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < recv_stall);

  // Send one command beat, idling at random beforehand; valid stays up
  // after the accepting edge until the next beat or the end of stimulus
  task automatic send_beat(in_t c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    in_data <= c;
    cmd_tally[c.command]++;
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic in_t make_cmd(cmd_e op, logic [ID_W-1:0] id, logic s, logic lim,
                                   logic [PRICE_W-1:0] p, logic signed [31:0] q,
                                   logic [REQ_W-1:0] lv);
    in_t c;
    c.command = op; c.order_id = id; c.side = s; c.is_limit = lim;
    c.price = p; c.quantity = q; c.depth_levels = lv;
    return c;
  endfunction

  // Mostly well-formed random command around a price of 1000
  function automatic in_t random_cmd();
    in_t c;
    int r;
    r = $urandom_range(99);
    c = make_cmd(CMD_ADD, $urandom_range(40), 1'($urandom_range(1)), 1,
                 0, $urandom_range(1, 500), REQ_W'($urandom_range(17)));
    if (r < 50) begin
      c.price = c.side ? 1000 + $urandom_range(1, 12) : 1000 - $urandom_range(0, 12);
      if ($urandom_range(19) == 0) c.is_limit = 0;
      if ($urandom_range(19) == 0) c.quantity = $urandom;
    end else if (r < 65) begin
      c.command = CMD_CANCEL;
      if (live_ids.size() > 0 && $urandom_range(3) != 0)
        c.order_id = live_ids[$urandom_range(live_ids.size() - 1)];
    end else if (r < 80) begin
      c.command = CMD_REDUCE;
      if (live_ids.size() > 0 && $urandom_range(3) != 0)
        c.order_id = live_ids[$urandom_range(live_ids.size() - 1)];
      if ($urandom_range(9) == 0) c.quantity = $urandom;
    end else if (r < 92) begin
      c.command = CMD_DEPTH;
      c.depth_levels = REQ_W'($urandom_range(31));
    end else begin
      c.command = cmd_e'(2'($urandom_range(3)));
      c.side = 1'($urandom_range(1));
      c.is_limit = 1'($urandom_range(1));
      c.depth_levels = REQ_W'($urandom_range(31));
      c.order_id = $urandom;
      c.price = $urandom;
      c.quantity = $urandom;
    end
    if (c.command == CMD_ADD) live_ids = {live_ids, c.order_id};
    return c;
  endfunction

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int drain;
    phase_idle = '{0, 56, 0, 29};
    phase_stall = '{0, 0, 56, 29};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: rejects in order, extremes, duplicates, every command
    send_beat(make_cmd(CMD_DEPTH, 0, 0, 0, 0, 0, 5));
    send_beat(make_cmd(CMD_CANCEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 1, 0, 5, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 0, 100, 0, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 0, 100, 32'sh8000_0000, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 0, 100, 5, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 1, 100, 32'sh7FFF_FFFF, 0));
    send_beat(make_cmd(CMD_ADD, 2, 0, 1, 100, 32'sh7FFF_FFFF, 0));
    send_beat(make_cmd(CMD_ADD, 1, 0, 1, 90, 7, 0));
    send_beat(make_cmd(CMD_ADD, 3, 1, 1, 100, 4, 0));
    send_beat(make_cmd(CMD_ADD, 3, 1, 1, 32'hFFFF_FFFF, 4, 0));
    send_beat(make_cmd(CMD_ADD, 4, 0, 1, 32'hFFFF_FFFF, 4, 0));
    send_beat(make_cmd(CMD_ADD, 4, 0, 1, 1, 1, 0));
    send_beat(make_cmd(CMD_DEPTH, 0, 0, 0, 0, 0, 31));
    send_beat(make_cmd(CMD_DEPTH, 0, 1, 0, 0, 0, 0));
    send_beat(make_cmd(CMD_REDUCE, 1, 0, 0, 0, 0, 0));
    send_beat(make_cmd(CMD_REDUCE, 9, 0, 0, 0, 3, 0));
    send_beat(make_cmd(CMD_REDUCE, 1, 0, 0, 0, 32'sh7FFF_FFFF, 0));
    send_beat(make_cmd(CMD_REDUCE, 1, 0, 0, 0, 32'sh7FFF_FFFF, 0));
    send_beat(make_cmd(CMD_REDUCE, 1, 0, 0, 0, 2, 0));
    send_beat(make_cmd(CMD_CANCEL, 1, 0, 0, 0, 0, 0));
    send_beat(make_cmd(CMD_CANCEL, 3, 0, 0, 0, 0, 0));
    send_beat(make_cmd(CMD_DEPTH, 0, 0, 0, 0, 0, 16));

    // Random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = phase_idle[ph];
      recv_stall = phase_stall[ph];
      for (int n = 0; n < 44; n++) send_beat(random_cmd());
    end
    send_idle = 0;
    recv_stall = 0;
    for (int n = 0; n < 10; n++) send_beat(random_cmd());
    in_valid <= 0;

    drain = 0;
    while (pending != 0 && drain < 200_000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (600) @(posedge clk_i);
    $display("Commands: %0d add, %0d cancel, %0d reduce, %0d depth; %0d results checked",
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], results_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb_limit_order_book_core: done, clean");
    else
      $display("tb_limit_order_book_core: done, errors");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/lob_pkg.sv
rtl/core/lob_ram.sv
rtl/core/lob_ctrl.sv
rtl/core/lob_dp.sv
rtl/core/limit_order_book_core.sv
tb/lob_book_checker.sv
tb/tb_limit_order_book_core.sv
